>>> src/stfm_pkg.sv
// Shared types and constants of the scanning threshold fault monitor.
`default_nettype none
package stfm_pkg;

  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned MUX_W    = 4;
  localparam int unsigned AIN_W    = 2;
  localparam int unsigned MUX_WAYS = 16;

  localparam logic [CNT_W-1:0]   COUNT_MAX      = 4'd15;
  localparam logic [LIMIT_W-1:0] TRIP_LIMIT_RST = 4'd10;
  localparam logic [AIN_W-1:0]   AIN_MUX        = 2'd3;
  localparam logic [MUX_W-1:0]   MUX_HOLD       = 4'(MUX_WAYS - 1);

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } stfm_req_e;

  typedef struct packed {
    logic over;
    logic trip;
  } stfm_flags_t;

endpackage
`default_nettype wire

>>> src/scanning_threshold_fault_monitor_core.sv
// Top level of the scanning threshold fault monitor with per-channel tables in RAM.
//
//   Channel  Handshake                  Payload
//   in       in_valid_i / in_stall_o    req_type_i, channel_i, sample_i, threshold_i
//   out      out_valid_o / out_stall_i  sampled_channel_o ... read_invalid_o
//   config   cfg_we_i                   cfg_wdata_i (trip limit)
//
// One item per cycle unless stalled; each item passes s1, then the result register.
// The channel status RAM is read at acceptance and written back as the item moves
// on to the result register, with the written word forwarded to the item accepted
// in that same cycle at the same address.
// Reset clears the scan pointer and the status valid bits at once and sets the trip
// limit to 10.
// A stalled output holds the result register; one more item may wait behind it.
`default_nettype none
module scanning_threshold_fault_monitor_core
  import stfm_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 19,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LIMIT_W-1:0]     cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             req_type_i,
  input  wire logic [CHAN_W-1:0]      channel_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [SAMPLE_BITS-1:0] threshold_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [CHAN_W-1:0]      sampled_channel_o,
  output logic                        over_threshold_o,
  output logic                        trip_o,
  output logic                        scan_done_o,
  output logic      [CHAN_W-1:0]      next_channel_o,
  output logic      [MUX_W-1:0]       mux_channel_o,
  output logic      [AIN_W-1:0]       analog_input_o,
  output logic      [SAMPLE_BITS-1:0] read_value_o,
  output logic                        read_ready_o,
  output logic                        read_invalid_o
);

  localparam int unsigned AW     = $clog2(NUM_CHANNELS);
  localparam int unsigned STAT_W = SAMPLE_BITS + CNT_W + 1;

  logic [LIMIT_W-1:0]      trip_limit_q;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic [NUM_CHANNELS-1:0] stat_vld_q;

  stfm_req_e               in_req;
  logic                    in_acc, in_range, in_is_smp, rd_en;
  logic [AW-1:0]           rd_addr, ptr_inc;
  logic                    wrap, ent_vld, fwd_hit;

  logic                    s1_valid_q;
  stfm_req_e               s1_req_q;
  logic [AW-1:0]           s1_addr_q;
  logic [SAMPLE_BITS-1:0]  s1_sample_q;
  logic                    s1_range_q, s1_done_q, s1_ent_vld_q, s1_fwd_q;
  logic [AW-1:0]           s1_next_q;
  logic [STAT_W-1:0]       s1_fwd_data_q;
  logic                    s1_adv, wb_en;

  logic [STAT_W-1:0]       stat_rdata, stat_cur, stat_new;
  logic [SAMPLE_BITS-1:0]  limit_rdata;
  logic [CNT_W-1:0]        cnt_new;
  logic                    rdy_new;
  stfm_flags_t             flags;

  logic [CHAN_W-1:0]       next_ch;

  logic [CHAN_W-1:0]       res_ch_d;
  logic                    res_over_d, res_trip_d, res_done_d;
  logic [MUX_W-1:0]        res_mux_d;
  logic [AIN_W-1:0]        res_ain_d;
  logic [SAMPLE_BITS-1:0]  res_rval_d;
  logic                    res_rrdy_d, res_rinv_d;

  assign in_req    = stfm_req_e'(req_type_i);
  assign in_range  = channel_i < CHAN_W'(NUM_CHANNELS);
  assign in_is_smp = in_req == REQ_SAMPLE;
  assign s1_adv    = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign wb_en     = s1_valid_q && s1_adv && (s1_req_q == REQ_SAMPLE);

  assign rd_addr = in_is_smp ? ptr_q : channel_i[AW-1:0];
  assign rd_en   = in_acc && (in_is_smp || ((in_req == REQ_READ) && in_range));
  assign wrap    = ptr_q == AW'(NUM_CHANNELS - 1);
  assign ptr_inc = wrap ? '0 : ptr_q + AW'(1);
  assign ptr_d   = (in_acc && in_is_smp) ? ptr_inc : ptr_q;
  assign fwd_hit = wb_en && (s1_addr_q == rd_addr);

  always_comb begin
    ent_vld = 1'b0;
    if (in_is_smp || in_range) begin
      ent_vld = stat_vld_q[rd_addr];
    end
  end

  stfm_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(NUM_CHANNELS)
  ) u_limit_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && (in_req == REQ_WRITE) && in_range),
    .waddr_i(channel_i[AW-1:0]),
    .wdata_i(threshold_i),
    .re_i   (in_acc && in_is_smp),
    .raddr_i(ptr_q),
    .rdata_o(limit_rdata)
  );

  stfm_ram #(
    .WIDTH(STAT_W),
    .DEPTH(NUM_CHANNELS)
  ) u_stat_ram (
    .clk_i  (clk_i),
    .we_i   (wb_en),
    .waddr_i(s1_addr_q),
    .wdata_i(stat_new),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(stat_rdata)
  );

  always_comb begin
    if (s1_fwd_q) begin
      stat_cur = s1_fwd_data_q;
    end else if (s1_ent_vld_q) begin
      stat_cur = stat_rdata;
    end else begin
      stat_cur = '0;
    end
  end

  stfm_update #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_update (
    .sample_i    (s1_sample_q),
    .limit_i     (limit_rdata),
    .cnt_i       (stat_cur[CNT_W:1]),
    .rdy_i       (stat_cur[0]),
    .trip_limit_i(trip_limit_q),
    .cnt_o       (cnt_new),
    .rdy_o       (rdy_new),
    .flags_o     (flags)
  );

  assign stat_new = {s1_sample_q, cnt_new, rdy_new};
  assign next_ch  = CHAN_W'(s1_next_q);

  always_comb begin
    res_ch_d   = '0;
    res_over_d = 1'b0;
    res_trip_d = 1'b0;
    res_done_d = 1'b0;
    res_rval_d = '0;
    res_rrdy_d = 1'b0;
    res_rinv_d = 1'b0;
    if (next_ch < CHAN_W'(MUX_WAYS)) begin
      res_mux_d = next_ch[MUX_W-1:0];
      res_ain_d = AIN_MUX;
    end else begin
      res_mux_d = MUX_HOLD;
      res_ain_d = AIN_W'(next_ch - CHAN_W'(MUX_WAYS));
    end
    case (s1_req_q)
      REQ_SAMPLE: begin
        res_ch_d   = CHAN_W'(s1_addr_q);
        res_over_d = flags.over;
        res_trip_d = flags.trip;
        res_done_d = s1_done_q;
      end
      REQ_WRITE: begin
        res_rinv_d = !s1_range_q;
      end
      REQ_READ: begin
        res_rinv_d = !s1_range_q;
        if (s1_range_q) begin
          res_rval_d = stat_cur[STAT_W-1 -: SAMPLE_BITS];
          res_rrdy_d = stat_cur[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_limit_q <= TRIP_LIMIT_RST;
      ptr_q        <= '0;
      stat_vld_q   <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        trip_limit_q <= cfg_wdata_i;
      end
      ptr_q <= ptr_d;
      if (wb_en) begin
        stat_vld_q[s1_addr_q] <= 1'b1;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_o <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q      <= in_req;
      s1_addr_q     <= rd_addr;
      s1_sample_q   <= sample_i;
      s1_range_q    <= in_range;
      s1_done_q     <= in_is_smp && wrap;
      s1_next_q     <= ptr_d;
      s1_ent_vld_q  <= ent_vld;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_data_q <= stat_new;
    end
    if (s1_adv && s1_valid_q) begin
      sampled_channel_o <= res_ch_d;
      over_threshold_o  <= res_over_d;
      trip_o            <= res_trip_d;
      scan_done_o       <= res_done_d;
      next_channel_o    <= next_ch;
      mux_channel_o     <= res_mux_d;
      analog_input_o    <= res_ain_d;
      read_value_o      <= res_rval_d;
      read_ready_o      <= res_rrdy_d;
      read_invalid_o    <= res_rinv_d;
    end
  end

endmodule
`default_nettype wire

>>> src/stfm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module stfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> src/stfm_update.sv
// Strike counter and ready flag update for one conversion sample.
`default_nettype none
module stfm_update
  import stfm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [SAMPLE_BITS-1:0] limit_i,
  input  wire logic [CNT_W-1:0]       cnt_i,
  input  wire logic                   rdy_i,
  input  wire logic [LIMIT_W-1:0]     trip_limit_i,
  output logic      [CNT_W-1:0]       cnt_o,
  output logic                        rdy_o,
  output stfm_flags_t                 flags_o
);

  logic [CNT_W-1:0] cnt_inc;

  always_comb begin
    cnt_inc = (cnt_i < COUNT_MAX) ? cnt_i + CNT_W'(1) : COUNT_MAX;
    flags_o = '0;
    cnt_o   = '0;
    rdy_o   = rdy_i;
    if (sample_i > limit_i) begin
      flags_o.over = 1'b1;
      if (cnt_inc > trip_limit_i) begin
        flags_o.trip = 1'b1;
      end else begin
        cnt_o = cnt_inc;
      end
    end else begin
      rdy_o = 1'b1;
    end
  end

endmodule
`default_nettype wire
